[hw/rtl/lbp_pkg.sv]
// lbp_pkg: shared constants, types and the code function for the 3x3 lbp stream
// no dependencies
package lbp_pkg;

    localparam int unsigned MAX_WIDTH  = 1024;
    localparam int unsigned ADDR_W     = $clog2(MAX_WIDTH);
    localparam int unsigned PIX_W      = 8;
    localparam int unsigned WIDTH_W    = 11;
    localparam int unsigned HEIGHT_W   = 12;
    localparam int unsigned CFG_DATA_W = 12;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned WIN_N      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = 11'd3;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = 12'd3;

    // neighbour positions in the row-major window, clockwise from top-left
    localparam logic [3:0] NB_POS [8] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3};
    localparam logic [3:0] CENTER_POS = 4'd4;

    typedef logic [WIN_N-1:0][PIX_W-1:0] t_win;

    typedef struct packed {
        logic emit;
        logic last;
    } t_ctl;

    function automatic logic [PIX_W-1:0] lbp_code(input t_win win);
        logic [PIX_W-1:0] code;
        code = '0;
        for (int k = 0; k < 8; k++) begin
            code[k] = (win[NB_POS[k]] >= win[CENTER_POS]);
        end
        return code;
    endfunction

endpackage

[hw/rtl/lbp_3x3_stream_top.sv]
// lbp_3x3_stream_top: raster pixel stream in, 3x3 local binary pattern codes out
// depends on lbp_pkg, lbp_line_buf, lbp_window
// a code passes the stage-one register and then the window result register after the pixel that completes its window
// throughput: one pixel per cycle while the output is not stalled, with one line memory read and write per pixel
// reset: counters and handshake clear at once; both line memories are then zeroed over all
// 1024 addresses, during which no pixel is accepted (configuration writes are taken)
module lbp_3x3_stream_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [lbp_pkg::PIX_W-1:0]        i_pixel,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [lbp_pkg::PIX_W-1:0]        o_lbp_code,
    output logic                             o_frame_last
);
    import lbp_pkg::*;

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [ADDR_W-1:0]   r_col;
    logic [HEIGHT_W-1:0] r_row;
    logic                r_s1_valid;
    logic [PIX_W-1:0]    r_s1_px;
    logic [ADDR_W-1:0]   r_s1_addr;
    t_ctl                r_s1_ctl;

    logic [WIDTH_W-1:0]  w_width_eff;
    logic [HEIGHT_W-1:0] w_height_eff;
    logic                w_row_end;
    logic                w_frame_end;
    logic                w_acc;
    logic                w_s1_adv;
    logic                w_clearing;
    logic                w_win_free;
    logic [PIX_W-1:0]    w_top;
    logic [PIX_W-1:0]    w_mid;
    t_ctl                n_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        priority if (r_frame_width < WIDTH_MIN) begin
            w_width_eff = WIDTH_MIN;
        end else if (r_frame_width > WIDTH_MAX) begin
            w_width_eff = WIDTH_MAX;
        end else begin
            w_width_eff = r_frame_width;
        end
        w_height_eff = (r_frame_height < HEIGHT_MIN) ? HEIGHT_MIN : r_frame_height;
    end

    assign w_row_end   = (WIDTH_W'(r_col) >= (w_width_eff - 1'b1));
    assign w_frame_end = w_row_end && (r_row >= (w_height_eff - 1'b1));

    assign w_s1_adv   = r_s1_valid && w_win_free;
    assign o_in_stall = w_clearing || (r_s1_valid && !w_s1_adv);
    assign w_acc      = i_in_valid && !o_in_stall;

    always_comb begin
        n_ctl.emit = (r_row >= HEIGHT_W'(2)) && (r_col >= ADDR_W'(2));
        n_ctl.last = w_frame_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                if (w_row_end) begin
                    r_col <= '0;
                    r_row <= w_frame_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_px   <= i_pixel;
            r_s1_addr <= r_col;
            r_s1_ctl  <= n_ctl;
        end
    end

    lbp_line_buf u_line_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_acc),
        .i_rd_addr  (r_col),
        .i_wr_en    (w_s1_adv),
        .i_wr_addr  (r_s1_addr),
        .i_wr_upper (w_mid),
        .i_wr_lower (r_s1_px),
        .o_top      (w_top),
        .o_mid      (w_mid),
        .o_clearing (w_clearing)
    );

    lbp_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_s1_adv),
        .i_ctl   (r_s1_ctl),
        .i_px    (r_s1_px),
        .i_top   (w_top),
        .i_mid   (w_mid),
        .i_stall (i_out_stall),
        .o_free  (w_win_free),
        .o_valid (o_out_valid),
        .o_code  (o_lbp_code),
        .o_last  (o_frame_last)
    );

    a_no_accept_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !w_acc)
        else $error("pixel accepted during line memory clear");

    a_row_end_wraps_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_row_end |=> r_col == '0)
        else $error("column counter did not wrap at row end");

    a_s1_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !w_s1_adv |=> r_s1_valid && $stable(r_s1_px) && $stable(r_s1_addr))
        else $error("stage one beat lost while stalled");

    a_frame_end_wraps_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_frame_end |=> r_row == '0)
        else $error("row counter did not wrap at frame end");

endmodule

[hw/rtl/lbp_line_buf.sv]
// lbp_line_buf: two 1024-entry row memories with registered read
// depends on lbp_pkg; clears both memories to zero after reset
module lbp_line_buf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [lbp_pkg::ADDR_W-1:0]  i_rd_addr,
    input  logic                        i_wr_en,
    input  logic [lbp_pkg::ADDR_W-1:0]  i_wr_addr,
    input  logic [lbp_pkg::PIX_W-1:0]   i_wr_upper,
    input  logic [lbp_pkg::PIX_W-1:0]   i_wr_lower,
    output logic [lbp_pkg::PIX_W-1:0]   o_top,
    output logic [lbp_pkg::PIX_W-1:0]   o_mid,
    output logic                        o_clearing
);
    import lbp_pkg::*;

    logic [PIX_W-1:0]  r_mem_upper [MAX_WIDTH];
    logic [PIX_W-1:0]  r_mem_lower [MAX_WIDTH];
    logic [PIX_W-1:0]  r_top;
    logic [PIX_W-1:0]  r_mid;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == ADDR_W'(MAX_WIDTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem_upper[r_clr_addr] <= '0;
            r_mem_lower[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem_upper[i_wr_addr] <= i_wr_upper;
            r_mem_lower[i_wr_addr] <= i_wr_lower;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_top <= r_mem_upper[i_rd_addr];
            r_mid <= r_mem_lower[i_rd_addr];
        end
    end

    assign o_top      = r_top;
    assign o_mid      = r_mid;
    assign o_clearing = r_clearing;

endmodule

[hw/rtl/lbp_window.sv]
// lbp_window: 3x3 pixel window, eight compares and the result register
// depends on lbp_pkg
module lbp_window (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  lbp_pkg::t_ctl              i_ctl,
    input  logic [lbp_pkg::PIX_W-1:0]  i_px,
    input  logic [lbp_pkg::PIX_W-1:0]  i_top,
    input  logic [lbp_pkg::PIX_W-1:0]  i_mid,
    input  logic                       i_stall,
    output logic                       o_free,
    output logic                       o_valid,
    output logic [lbp_pkg::PIX_W-1:0]  o_code,
    output logic                       o_last
);
    import lbp_pkg::*;

    t_win             r_win;
    t_win             n_win;
    logic             r_valid;
    logic [PIX_W-1:0] r_code;
    logic             r_last;
    logic             w_free;

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = i_top;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = i_mid;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = i_px;
    end

    assign w_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_win <= n_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= i_load && i_ctl.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_free && i_load) begin
            r_code <= lbp_code(n_win);
            r_last <= i_ctl.last;
        end
    end

    assign o_free  = w_free;
    assign o_valid = r_valid;
    assign o_code  = r_code;
    assign o_last  = r_last;

endmodule
